>>> design/charger_link_frame_builder_macros.svh
// ----------------------------------------------------------------------------
// charger link frame builder assertion macros
// shared property forms for the port checker, sampled on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef CHARGER_LINK_FRAME_BUILDER_MACROS_SVH
`define CHARGER_LINK_FRAME_BUILDER_MACROS_SVH

// consequent checked on the same edge as the antecedent
`define CLFB_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked on the following edge
`define CLFB_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/clfb_pkg.sv
// ----------------------------------------------------------------------------
// clfb_pkg
// shared types, codes and helpers of the charger link frame builder
// ----------------------------------------------------------------------------
package clfb_pkg;

  // frame type codes
  localparam logic [7:0] TYPE_REPORT  = 8'h01;
  localparam logic [7:0] TYPE_SETUP   = 8'h03;
  localparam logic [7:0] TYPE_SHORT_A = 8'h11;
  localparam logic [7:0] TYPE_SHORT_B = 8'h12;

  // fixed frame bytes
  localparam logic [7:0] SYNC_HI   = 8'hAA;
  localparam logic [7:0] SYNC_LO   = 8'h55;
  localparam logic [7:0] TAIL_MARK = 8'h11;

  // frame lengths in bytes
  localparam logic [4:0] LEN_REPORT = 5'd13;
  localparam logic [4:0] LEN_SETUP  = 5'd17;
  localparam logic [4:0] LEN_SHORT  = 5'd6;

  // configuration register indexes
  localparam logic [2:0] CFG_BATTERY  = 3'd0;
  localparam logic [2:0] CFG_POSITION = 3'd1;
  localparam logic [2:0] CFG_ADDRESS  = 3'd2;
  localparam logic [2:0] CFG_MODE     = 3'd3;
  localparam logic [2:0] CFG_VMODE    = 3'd4;
  localparam logic [2:0] CFG_VREF     = 3'd5;
  localparam logic [2:0] CFG_IREF     = 3'd6;

  // configuration reset values
  localparam logic [31:0] RST_BATTERY  = 32'h003C_000F;
  localparam logic [31:0] RST_POSITION = 32'h000B_0009;
  localparam logic [31:0] RST_ADDRESS  = 32'h0001_0002;
  localparam logic [7:0]  RST_MODE     = 8'd1;
  localparam logic        RST_VMODE    = 1'b1;
  localparam logic [14:0] RST_VREF     = 15'd2400;
  localparam logic [14:0] RST_IREF     = 15'd300;

  // default depth of the request queue
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_REPORT,
    KIND_SETUP,
    KIND_SHORT
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ftype;
  } req_t;

  typedef struct packed {
    logic head_valid;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic [31:0] battery;
    logic [31:0] position;
    logic [31:0] address;
    logic [7:0]  mode;
  } cfg_t;

  function automatic logic [4:0] frame_len(input kind_t kind);
    logic [4:0] len;
    case (kind)
      KIND_REPORT: len = LEN_REPORT;
      KIND_SETUP:  len = LEN_SETUP;
      default:     len = LEN_SHORT;
    endcase
    return len;
  endfunction

  // byte of a word, index 0 is bits 31..24
  function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] sel);
    logic [7:0] b;
    case (sel)
      2'd0:    b = w[31:24];
      2'd1:    b = w[23:16];
      2'd2:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

endpackage

>>> design/clfb_front.sv
// ----------------------------------------------------------------------------
// clfb_front
// takes frame requests, classifies the type and queues the known ones
// ----------------------------------------------------------------------------
module clfb_front (
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] frame_type
  input  clfb_pkg::q_status_t  q_status,
  output logic                 push,
  output clfb_pkg::req_t       push_req
);

  logic known;

  always_comb begin
    known         = 1'b1;
    push_req.ftype = s_tdata;
    case (s_tdata)
      clfb_pkg::TYPE_REPORT:  push_req.kind = clfb_pkg::KIND_REPORT;
      clfb_pkg::TYPE_SETUP:   push_req.kind = clfb_pkg::KIND_SETUP;
      clfb_pkg::TYPE_SHORT_A,
      clfb_pkg::TYPE_SHORT_B: push_req.kind = clfb_pkg::KIND_SHORT;
      default: begin
        push_req.kind = clfb_pkg::KIND_SHORT;
        known         = 1'b0;
      end
    endcase
  end

  // unknown types are taken and dropped
  assign s_tready = !q_status.full;
  assign push     = s_tvalid && s_tready && known;

endmodule

>>> design/clfb_queue.sv
// ----------------------------------------------------------------------------
// clfb_queue
// short request queue between the classifier and the byte sequencer
// ----------------------------------------------------------------------------
module clfb_queue #(
  parameter int DEPTH = clfb_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  clfb_pkg::req_t      push_req,
  input  logic                pop,
  output clfb_pkg::req_t      head,
  output clfb_pkg::q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  clfb_pkg::req_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign status.full       = (count == CNT_W'(DEPTH));
  assign status.head_valid = (count != '0);
  assign do_push = push && !status.full;
  assign do_pop  = pop && status.head_valid;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/clfb_ref_split.sv
// ----------------------------------------------------------------------------
// clfb_ref_split
// splits the selected reference into whole and hundredths parts
// ----------------------------------------------------------------------------
module clfb_ref_split (
  input  logic        clk,
  input  logic        voltage_mode,
  input  logic [14:0] voltage_ref_centi,
  input  logic [14:0] current_ref_centi,
  output logic [7:0]  whole,
  output logic [6:0]  hund
);

  // ref / 100 as (ref * 5243) >> 19, exact for every 15-bit value
  localparam logic [12:0] RECIP       = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  logic [14:0] ref_q;
  logic [14:0] ref_d;
  logic [27:0] prod_q;
  logic [8:0]  whole_full;
  logic [15:0] back_mul;
  logic [14:0] rem_full;

  assign whole_full = prod_q[RECIP_SHIFT +: 9];
  assign back_mul   = 16'(whole_full) * 16'd100;
  assign rem_full   = ref_d - back_mul[14:0];

  always_ff @(posedge clk) begin
    ref_q  <= voltage_mode ? voltage_ref_centi : current_ref_centi;
    ref_d  <= ref_q;
    prod_q <= 28'(ref_q) * 28'(RECIP);
    whole  <= whole_full[7:0];
    hund   <= rem_full[6:0];
  end

endmodule

>>> design/clfb_back.sv
// ----------------------------------------------------------------------------
// clfb_back
// byte sequencer: walks the head request and fills the output register
// ----------------------------------------------------------------------------
module clfb_back (
  input  logic                clk,
  input  logic                rst,
  input  clfb_pkg::req_t      head,
  input  clfb_pkg::q_status_t q_status,
  output logic                pop,
  input  clfb_pkg::cfg_t      cfg,
  input  logic [7:0]          whole,
  input  logic [6:0]          hund,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // [7:0] tx_byte
  output logic                m_tlast    // last_byte
);

  logic [4:0] idx;
  logic [4:0] len;
  logic [4:0] last_idx;
  logic [4:0] sum_start;
  logic [7:0] acc;
  logic [7:0] cur_byte;
  logic       is_last;
  logic       load;

  assign len       = clfb_pkg::frame_len(head.kind);
  assign last_idx  = len - 5'd1;
  assign sum_start = len - 5'd5;
  assign is_last   = (idx == last_idx);
  assign load      = q_status.head_valid && (!m_tvalid || m_tready);
  assign pop       = load && is_last;

  always_comb begin
    cur_byte = 8'h00;
    if (is_last) begin
      cur_byte = acc;
    end else if (idx < 5'd4) begin
      case (idx[1:0])
        2'd0:    cur_byte = clfb_pkg::SYNC_HI;
        2'd1:    cur_byte = clfb_pkg::SYNC_LO;
        2'd2:    cur_byte = {3'b000, len};
        default: cur_byte = head.ftype;
      endcase
    end else begin
      case (head.kind)
        clfb_pkg::KIND_REPORT: begin
          cur_byte = (idx < 5'd8) ? 8'h00 : clfb_pkg::word_byte(cfg.battery, idx[1:0]);
        end
        clfb_pkg::KIND_SETUP: begin
          if (idx < 5'd8) begin
            cur_byte = clfb_pkg::word_byte(cfg.position, idx[1:0]);
          end else if (idx < 5'd12) begin
            cur_byte = clfb_pkg::word_byte(cfg.address, idx[1:0]);
          end else if (idx == 5'd12) begin
            cur_byte = cfg.mode;
          end else if (idx == 5'd13) begin
            cur_byte = whole;
          end else if (idx == 5'd14) begin
            cur_byte = {1'b0, hund};
          end else begin
            cur_byte = clfb_pkg::TAIL_MARK;
          end
        end
        default: cur_byte = head.ftype;
      endcase
    end
  end

  // checksum runs over the four bytes before the last one
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= cur_byte;
      m_tlast <= is_last;
      acc     <= (idx == sum_start) ? cur_byte : acc + cur_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        idx      <= is_last ? '0 : idx + 5'd1;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

>>> design/charger_link_frame_builder.sv
// ----------------------------------------------------------------------------
// charger_link_frame_builder
// turns frame-type requests into the byte stream of a charger link frame
// ----------------------------------------------------------------------------
// each accepted request of a known type on the slave side produces a whole frame
// on the master side, tlast on the closing checksum byte: type 0x01 gives
// 13 bytes, 0x03 gives 17 and 0x11 or 0x12 give 6; any other type is taken
// and produces nothing. the byte sequencer emits one byte per cycle while
// m_tready does not stall the output register, and the next queued frame
// follows with no gap. requests wait in a short queue (QUEUE_DEPTH entries)
// and tready drops only while it is full, so a new request is normally taken
// while the previous frame is still going out. configuration registers are to
// be written through cfg_we/cfg_addr/cfg_wdata only while the block is idle;
// the block itself does not enforce this. the reference split (whole and
// hundredths) follows a write through its selection, product and output registers
module charger_link_frame_builder #(
  parameter int QUEUE_DEPTH = clfb_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] frame_type
  // byte channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [7:0] tx_byte
  output logic        m_tlast,    // last_byte
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  // configuration registers
  logic [31:0] battery_report_word;
  logic [31:0] position_word;
  logic [31:0] address_word;
  logic [7:0]  mode_code;
  logic        voltage_mode;
  logic [14:0] voltage_ref_centi;
  logic [14:0] current_ref_centi;

  clfb_pkg::cfg_t      cfg;
  clfb_pkg::req_t      push_req;
  clfb_pkg::req_t      head;
  clfb_pkg::q_status_t q_status;
  logic                push;
  logic                pop;
  logic [7:0]          whole;
  logic [6:0]          hund;

  // register writes, indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      battery_report_word <= clfb_pkg::RST_BATTERY;
      position_word       <= clfb_pkg::RST_POSITION;
      address_word        <= clfb_pkg::RST_ADDRESS;
      mode_code           <= clfb_pkg::RST_MODE;
      voltage_mode        <= clfb_pkg::RST_VMODE;
      voltage_ref_centi   <= clfb_pkg::RST_VREF;
      current_ref_centi   <= clfb_pkg::RST_IREF;
    end else if (cfg_we) begin
      case (cfg_addr)
        clfb_pkg::CFG_BATTERY:  battery_report_word <= cfg_wdata;
        clfb_pkg::CFG_POSITION: position_word       <= cfg_wdata;
        clfb_pkg::CFG_ADDRESS:  address_word        <= cfg_wdata;
        clfb_pkg::CFG_MODE:     mode_code           <= cfg_wdata[7:0];
        clfb_pkg::CFG_VMODE:    voltage_mode        <= cfg_wdata[0];
        clfb_pkg::CFG_VREF:     voltage_ref_centi   <= cfg_wdata[14:0];
        clfb_pkg::CFG_IREF:     current_ref_centi   <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  assign cfg.battery  = battery_report_word;
  assign cfg.position = position_word;
  assign cfg.address  = address_word;
  assign cfg.mode     = mode_code;

  // front: accept and classify
  clfb_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_status (q_status),
    .push     (push),
    .push_req (push_req)
  );

  // queue between front and back
  clfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // reference whole / hundredths split, kept up to date from the registers
  clfb_ref_split u_ref_split (
    .clk               (clk),
    .voltage_mode      (voltage_mode),
    .voltage_ref_centi (voltage_ref_centi),
    .current_ref_centi (current_ref_centi),
    .whole             (whole),
    .hund              (hund)
  );

  // back: byte sequencer and output register
  clfb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .cfg      (cfg),
    .whole    (whole),
    .hund     (hund),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

>>> design/clfb_checker.sv
// ----------------------------------------------------------------------------
// clfb_checker
// port-level checks of the frame stream, bound to the top level
// ----------------------------------------------------------------------------
`include "charger_link_frame_builder_macros.svh"

module clfb_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // position of the current byte within its frame
  logic [4:0] pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (m_tvalid && m_tready) begin
      pos <= m_tlast ? '0 : pos + 5'd1;
    end
  end

  `CLFB_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled byte changed")
  `CLFB_HOLDS(a_sync_hi, m_tvalid && pos == 5'd0, m_tdata == 8'hAA, "frame does not open with AA")
  `CLFB_HOLDS(a_sync_lo, m_tvalid && pos == 5'd1, m_tdata == 8'h55, "second frame byte is not 55")
  `CLFB_HOLDS(a_last_pos, m_tvalid && m_tlast, pos == 5'd5 || pos == 5'd12 || pos == 5'd16, "frame ends at a bad length")

endmodule

bind charger_link_frame_builder clfb_checker u_clfb_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// charger link frame builder testbench
// sends frame-type requests under random gaps and back-pressure, rebuilds
// every expected frame byte from a local copy of the registers and checks
// each byte and its tlast in order on the master side
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // register index past the end of the list, writes to it are dropped
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  // cycles let pass before a register write, long enough for every queued
  // request (ignored ones included) to have left the block
  localparam int DRAIN_CYCLES = (clfb_pkg::QUEUE_DEPTH + 2) * 17 + 8;
  // the reference split follows a write through its selection, product and output registers
  localparam int SETTLE_CYCLES = 4;
  // quiet cycles after the last expected byte, to catch stray output
  localparam int TAIL_CYCLES = 64;
  // cycles with no handshake at all before the run is given up
  localparam int WATCHDOG_LIMIT = 4000;
  // random requests of a known type per register setting
  localparam int PHASE_FRAMES = 53;
  localparam int RANDOM_PHASES = 5;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wdata;

  // local copy of the configuration registers
  logic [31:0] battery_word;
  logic [31:0] position_word;
  logic [31:0] address_word;
  logic [7:0]  mode_byte;
  logic        use_voltage;
  logic [14:0] voltage_centi;
  logic [14:0] current_centi;

  frame_byte_t frames_due[$];
  int          mismatches;
  int          quiet_cycles;
  bit          idling_on;

  charger_link_frame_builder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // [7:0] frame_type
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // [7:0] tx_byte
    .m_tlast   (m_tlast),    // last_byte
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // gap length: mostly none or short, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(8, 40);
    end
  endfunction

  // builds the whole frame for one request and queues its bytes,
  // returns the number of bytes queued (none for an unknown type)
  function automatic int predict_frame(input logic [7:0] ftype);
    logic [7:0]  body[17];
    logic [14:0] ref_centi;
    logic [7:0]  sum;
    int          n;
    n = 0;
    if (ftype != clfb_pkg::TYPE_REPORT && ftype != clfb_pkg::TYPE_SETUP &&
        ftype != clfb_pkg::TYPE_SHORT_A && ftype != clfb_pkg::TYPE_SHORT_B) begin
      return 0;
    end
    body[0] = clfb_pkg::SYNC_HI;
    body[1] = clfb_pkg::SYNC_LO;
    case (ftype)
      clfb_pkg::TYPE_REPORT: body[2] = {3'b000, clfb_pkg::LEN_REPORT};
      clfb_pkg::TYPE_SETUP:  body[2] = {3'b000, clfb_pkg::LEN_SETUP};
      default:               body[2] = {3'b000, clfb_pkg::LEN_SHORT};
    endcase
    body[3] = ftype;
    n = 4;
    if (ftype == clfb_pkg::TYPE_REPORT) begin
      // four zero bytes, then the battery report high byte first
      for (int i = 0; i < 4; i++) begin
        body[n] = 8'h00;
        n++;
      end
      for (int i = 3; i >= 0; i--) begin
        body[n] = battery_word[i*8 +: 8];
        n++;
      end
    end else if (ftype == clfb_pkg::TYPE_SETUP) begin
      for (int i = 3; i >= 0; i--) begin
        body[n] = position_word[i*8 +: 8];
        n++;
      end
      for (int i = 3; i >= 0; i--) begin
        body[n] = address_word[i*8 +: 8];
        n++;
      end
      body[n] = mode_byte;
      n++;
      // whole part wraps at 256 when the reference is past 255.99
      ref_centi = use_voltage ? voltage_centi : current_centi;
      body[n] = 8'(ref_centi / 15'd100);
      n++;
      body[n] = 8'(ref_centi % 15'd100);
      n++;
      body[n] = clfb_pkg::TAIL_MARK;
      n++;
    end else begin
      body[n] = ftype;
      n++;
    end
    // checksum over the four bytes just before it, wrapping at 8 bits
    sum = body[n-1] + body[n-2] + body[n-3] + body[n-4];
    body[n] = sum;
    n++;
    for (int i = 0; i < n; i++) begin
      frames_due.push_back('{data: body[i], last: (i == n - 1)});
    end
    return n;
  endfunction

  // one request on the slave side, predicted once it is taken,
  // followed by an optional gap with tvalid low
  task automatic send_request(input logic [7:0] ftype, output int bytes_due);
    int gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= ftype;
    do @(posedge clk); while (!s_tready);
    bytes_due = predict_frame(ftype);
    gap = idling_on ? gap_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_list(input logic [7:0] types[$]);
    int dummy;
    foreach (types[i]) send_request(types[i], dummy);
  endtask

  // waits for every expected byte, then for the queue to run dry
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write enable stays high across back-to-back writes
  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    case (idx)
      clfb_pkg::CFG_BATTERY:  battery_word  = value;
      clfb_pkg::CFG_POSITION: position_word = value;
      clfb_pkg::CFG_ADDRESS:  address_word  = value;
      clfb_pkg::CFG_MODE:     mode_byte     = value[7:0];
      clfb_pkg::CFG_VMODE:    use_voltage   = value[0];
      clfb_pkg::CFG_VREF:     voltage_centi = value[14:0];
      clfb_pkg::CFG_IREF:     current_centi = value[14:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= 32'h0;
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // every frame type under the reset values of the registers
  task automatic test_frame_types();
    send_list('{clfb_pkg::TYPE_REPORT, clfb_pkg::TYPE_SETUP,
                clfb_pkg::TYPE_SHORT_A, clfb_pkg::TYPE_SHORT_B});
  endtask

  // unknown types are swallowed and must not disturb the frames around them
  task automatic test_unknown_types();
    send_list('{8'h00, clfb_pkg::TYPE_SHORT_A, 8'hFF, 8'h02, 8'h13,
                clfb_pkg::TYPE_REPORT});
  endtask

  // whole and hundredths split at its edges, both reference sources
  task automatic test_reference_split();
    wait_idle();
    write_register(clfb_pkg::CFG_VMODE, 32'd1);
    write_register(clfb_pkg::CFG_VREF, 32'd0);
    write_register(clfb_pkg::CFG_IREF, 32'd25599);
    end_writes();
    send_list('{clfb_pkg::TYPE_SETUP});
    wait_idle();
    write_register(clfb_pkg::CFG_VREF, 32'd25599);
    end_writes();
    send_list('{clfb_pkg::TYPE_SETUP});
    wait_idle();
    // past 255.99 the whole part wraps
    write_register(clfb_pkg::CFG_VREF, 32'd32767);
    end_writes();
    send_list('{clfb_pkg::TYPE_SETUP});
    wait_idle();
    write_register(clfb_pkg::CFG_VMODE, 32'd0);
    end_writes();
    send_list('{clfb_pkg::TYPE_SETUP});
    wait_idle();
    write_register(clfb_pkg::CFG_IREF, 32'd99);
    end_writes();
    send_list('{clfb_pkg::TYPE_SETUP});
  endtask

  // all-ones values with junk above the register widths, a write to the
  // spare index, then everything at zero
  task automatic test_register_extremes();
    wait_idle();
    write_register(clfb_pkg::CFG_BATTERY, 32'hFFFF_FFFF);
    write_register(clfb_pkg::CFG_POSITION, 32'hFFFF_FFFF);
    write_register(clfb_pkg::CFG_ADDRESS, 32'hFFFF_FFFF);
    write_register(clfb_pkg::CFG_MODE, 32'hFFFF_FFFF);
    write_register(clfb_pkg::CFG_VMODE, 32'hFFFF_FFFF);
    write_register(clfb_pkg::CFG_VREF, 32'hFFFF_FFFF);
    write_register(clfb_pkg::CFG_IREF, 32'hFFFF_FFFF);
    write_register(CFG_UNUSED, 32'h1234_5678);
    end_writes();
    send_list('{clfb_pkg::TYPE_REPORT, clfb_pkg::TYPE_SETUP});
    wait_idle();
    write_register(clfb_pkg::CFG_BATTERY, 32'h0);
    write_register(clfb_pkg::CFG_POSITION, 32'h0);
    write_register(clfb_pkg::CFG_ADDRESS, 32'h0);
    write_register(clfb_pkg::CFG_MODE, 32'h0);
    write_register(clfb_pkg::CFG_VMODE, 32'h0);
    write_register(clfb_pkg::CFG_VREF, 32'h0);
    write_register(clfb_pkg::CFG_IREF, 32'h0);
    end_writes();
    send_list('{clfb_pkg::TYPE_REPORT, clfb_pkg::TYPE_SETUP, clfb_pkg::TYPE_SHORT_B});
  endtask

  // random requests over several random settings, one phase with no idling
  task automatic test_random_frames();
    int          framed;
    int          bytes_due;
    logic [7:0]  ftype;
    logic [31:0] vref_value;
    logic [31:0] iref_value;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      // references mostly in range, now and then the full register width
      vref_value = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 25599);
      iref_value = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 25599);
      write_register(clfb_pkg::CFG_BATTERY, $urandom);
      write_register(clfb_pkg::CFG_POSITION, $urandom);
      write_register(clfb_pkg::CFG_ADDRESS, $urandom);
      write_register(clfb_pkg::CFG_MODE, $urandom);
      write_register(clfb_pkg::CFG_VMODE, $urandom);
      write_register(clfb_pkg::CFG_VREF, vref_value);
      write_register(clfb_pkg::CFG_IREF, iref_value);
      end_writes();
      idling_on = (p != 2);
      framed = 0;
      while (framed < PHASE_FRAMES) begin
        if ($urandom_range(0, 4) == 0) begin
          ftype = 8'($urandom);
        end else begin
          case ($urandom_range(0, 3))
            0:       ftype = clfb_pkg::TYPE_REPORT;
            1:       ftype = clfb_pkg::TYPE_SETUP;
            2:       ftype = clfb_pkg::TYPE_SHORT_A;
            default: ftype = clfb_pkg::TYPE_SHORT_B;
          endcase
        end
        send_request(ftype, bytes_due);
        if (bytes_due > 0) framed++;
      end
    end
    idling_on = 1'b1;
  endtask

  // master side back-pressure
  always @(negedge clk) begin : ready_driver
    static int hold = 0;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold > 0) begin
      hold = hold - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (idling_on && $urandom_range(0, 2) == 0) hold = gap_len();
    end
  end

  // byte checker, oldest expectation first
  always @(posedge clk) begin : byte_checker
    frame_byte_t exp_byte;
    if (!rst && m_tvalid && m_tready) begin
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected byte: expected none, got data %02h last %0b",
                 $time, m_tdata, m_tlast);
        mismatches++;
      end else begin
        exp_byte = frames_due.pop_front();
        if (m_tdata !== exp_byte.data) begin
          $display("%0t: tx_byte mismatch: expected %02h, got %02h",
                   $time, exp_byte.data, m_tdata);
          mismatches++;
        end
        if (m_tlast !== exp_byte.last) begin
          $display("%0t: last_byte mismatch: expected %0b, got %0b",
                   $time, exp_byte.last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  // watchdog: gives up after too long without any handshake
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    mismatches    = 0;
    idling_on     = 1'b1;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = 8'h00;
    cfg_we        = 1'b0;
    cfg_addr      = 3'd0;
    cfg_wdata     = 32'h0;
    battery_word  = clfb_pkg::RST_BATTERY;
    position_word = clfb_pkg::RST_POSITION;
    address_word  = clfb_pkg::RST_ADDRESS;
    mode_byte     = clfb_pkg::RST_MODE;
    use_voltage   = clfb_pkg::RST_VMODE;
    voltage_centi = clfb_pkg::RST_VREF;
    current_centi = clfb_pkg::RST_IREF;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_frame_types();
    test_unknown_types();
    test_reference_split();
    test_register_extremes();
    test_random_frames();

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> charger_link_frame_builder.f
+incdir+design
design/clfb_pkg.sv
design/clfb_front.sv
design/clfb_queue.sv
design/clfb_ref_split.sv
design/clfb_back.sv
design/charger_link_frame_builder.sv
design/clfb_checker.sv
tb/sv/tb_top.sv
